[rtl/stp_ramp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper ramp package
// Shared constants for the stepper linear speed ramp: register indexes,
// request kinds, direction codes and reset values.
// ----------------------------------------------------------------------------
package stp_ramp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_PERCENT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_DIRECTION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_CHECK_EN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_LEVEL    = 3'd4;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [1:0] DIR_KEEP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  localparam logic [15:0] STEPS_RESET  = 16'd200;
  localparam logic [6:0]  DUTY_RESET   = 7'd50;
  localparam logic [15:0] RPM_SECONDS  = 16'd60;

endpackage

[rtl/stepper_linear_speed_ramp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper linear speed ramp
// Ramps a stepper's commanded rpm linearly toward a target on millisecond
// ticks and reports the resulting step clock frequency.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/stall): a start request carries a
// ramp length, a target rpm and a direction request; a tick request carries
// the sampled fault level. Every request gives exactly one result on the
// out_ channel, which is held in an output register until taken.
// The two variable divisions go through one shared restoring divider that
// retires one quotient bit per cycle. The step frequency is formed by a
// multiply registered in S_FREQ and a reciprocal multiply by 1/60 in S_FDIV.
// A tick that does not change the rpm goes straight to the output; a start
// without a ramp runs no division, a start with no speed difference one, and
// a start with a ramp and a speed difference two.
// The input side is stalled while a request is in work. A new request is
// taken while an earlier result still waits; if out_stall holds, the block
// finishes the work and then waits with its result until the output is free.
// Configuration writes are always ready and are meant for idle periods.
// Reset clears the ramp state, sets the registers to their defaults and
// leaves the output channel empty.
// ----------------------------------------------------------------------------
module stepper_linear_speed_ramp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [15:0]                          in_ramp_ms,
  input  logic [15:0]                          in_target_rpm,
  input  logic [1:0]                           in_dir_request,
  input  logic                                 in_fault_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [15:0]                          out_step_freq_hz,
  output logic                                 out_clock_enable,
  output logic                                 out_dir_level,
  output logic [6:0]                           out_clk_duty_percent,
  output logic                                 out_ramp_busy,
  output logic                                 out_fault_stop,
  output logic [15:0]                          out_current_rpm,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stp_ramp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stp_ramp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_CUR   = 3'd3;
  localparam logic [2:0] S_DLY   = 3'd4;
  localparam logic [2:0] S_FREQ  = 3'd5;
  localparam logic [2:0] S_FDIV  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int DIV_STEPS = 32;

  // A product at or above 65536 * 60 saturates the frequency. Below it, the
  // product divided by 4 is under 2^20 and divides exactly by 15 through the
  // reciprocal ceil(2^24 / 15).
  localparam logic [31:0] FREQ_SAT_PROD = 32'd3932160;
  localparam logic [40:0] RECIP_15      = 41'd1118482;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic [15:0] r;
    r = (|v[31:16]) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

  logic [15:0] steps_per_rev_r;
  logic [6:0]  duty_percent_r;
  logic        swap_direction_r;
  logic        fault_check_en_r;
  logic        fault_level_r;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] ramp_in_r, ramp_in_nxt;
  logic [15:0] target_in_r, target_in_nxt;
  logic [1:0]  dreq_in_r, dreq_in_nxt;
  logic        fault_in_r, fault_in_nxt;

  logic [15:0] freq_now_r, freq_now_nxt;
  logic [15:0] rpm_now_r, rpm_now_nxt;
  logic [15:0] rpm_goal_r, rpm_goal_nxt;
  logic        going_down_r, going_down_nxt;
  logic [15:0] step_delay_r, step_delay_nxt;
  logic [15:0] delay_count_r, delay_count_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] ramp_len_r, ramp_len_nxt;
  logic        busy_flag_r, busy_flag_nxt;
  logic        clock_on_r, clock_on_nxt;
  logic        dir_logical_r, dir_logical_nxt;
  logic        fault_hit_r, fault_hit_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_freq_r;
  logic        out_clock_r;
  logic        out_dir_r;
  logic [6:0]  out_duty_r;
  logic        out_busy_r;
  logic        out_fault_r;
  logic [15:0] out_rpm_r;
  logic        load_out;

  logic        div_run_r;
  logic [4:0]  div_cnt_r;
  logic [31:0] div_quo_r;
  logic [15:0] div_rem_r;
  logic [15:0] div_den_r;
  logic [16:0] div_shift;
  logic        div_ge;
  logic [16:0] div_sub;
  logic        div_start;
  logic [31:0] div_num;
  logic [15:0] div_den;

  logic [15:0] cur16;
  logic [15:0] diff16;
  logic        cur_down;
  logic [15:0] elapsed_inc;
  logic [15:0] delay_inc;
  logic [15:0] rpm_stepped;
  logic [31:0] freq_x60;
  logic [31:0] rpm_prod;
  logic [31:0] freq_prod_r;
  logic [40:0] recip_prod;
  logic [15:0] freq_div60;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_per_rev_r  <= stp_ramp_pkg::STEPS_RESET;
      duty_percent_r   <= stp_ramp_pkg::DUTY_RESET;
      swap_direction_r <= 1'b0;
      fault_check_en_r <= 1'b0;
      fault_level_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stp_ramp_pkg::REG_STEPS_PER_REV:  steps_per_rev_r  <= cfg_data;
        stp_ramp_pkg::REG_DUTY_PERCENT:   duty_percent_r   <= cfg_data[6:0];
        stp_ramp_pkg::REG_SWAP_DIRECTION: swap_direction_r <= cfg_data[0];
        stp_ramp_pkg::REG_FAULT_CHECK_EN: fault_check_en_r <= cfg_data[0];
        stp_ramp_pkg::REG_FAULT_LEVEL:    fault_level_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign div_shift = {div_rem_r, div_quo_r[31]};
  assign div_ge    = div_shift >= {1'b0, div_den_r};
  assign div_sub   = div_shift - {1'b0, div_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
    end else if (div_start) begin
      div_run_r <= 1'b1;
    end else if (div_run_r && div_cnt_r == 5'(DIV_STEPS - 1)) begin
      div_run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_quo_r <= div_num;
      div_rem_r <= '0;
      div_den_r <= div_den;
      div_cnt_r <= '0;
    end else if (div_run_r) begin
      div_rem_r <= div_ge ? div_sub[15:0] : div_shift[15:0];
      div_quo_r <= {div_quo_r[30:0], div_ge};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FREQ) begin
      freq_prod_r <= rpm_prod;
    end
  end

  assign freq_x60    = {10'b0, freq_now_r, 6'b0} - {14'b0, freq_now_r, 2'b0};
  assign rpm_prod    = {16'b0, rpm_now_r} * {16'b0, steps_per_rev_r};
  assign recip_prod  = {21'b0, freq_prod_r[21:2]} * RECIP_15;
  assign freq_div60  = (freq_prod_r >= FREQ_SAT_PROD) ? 16'hFFFF : recip_prod[39:24];
  assign cur16       = sat16(div_quo_r);
  assign cur_down    = target_in_r < cur16;
  assign diff16      = cur_down ? (cur16 - target_in_r) : (target_in_r - cur16);
  assign elapsed_inc = elapsed_r + 16'd1;
  assign delay_inc   = delay_count_r + 16'd1;
  assign rpm_stepped = (rpm_now_r == rpm_goal_r) ? rpm_now_r :
                       (going_down_r ? rpm_now_r - 16'd1 : rpm_now_r + 16'd1);
  assign load_out    = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt       = state_r;
    ramp_in_nxt     = ramp_in_r;
    target_in_nxt   = target_in_r;
    dreq_in_nxt     = dreq_in_r;
    fault_in_nxt    = fault_in_r;
    freq_now_nxt    = freq_now_r;
    rpm_now_nxt     = rpm_now_r;
    rpm_goal_nxt    = rpm_goal_r;
    going_down_nxt  = going_down_r;
    step_delay_nxt  = step_delay_r;
    delay_count_nxt = delay_count_r;
    elapsed_nxt     = elapsed_r;
    ramp_len_nxt    = ramp_len_r;
    busy_flag_nxt   = busy_flag_r;
    clock_on_nxt    = clock_on_r;
    dir_logical_nxt = dir_logical_r;
    fault_hit_nxt   = fault_hit_r;
    div_start       = 1'b0;
    div_num         = '0;
    div_den         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ramp_in_nxt   = in_ramp_ms;
          target_in_nxt = in_target_rpm;
          dreq_in_nxt   = in_dir_request;
          fault_in_nxt  = in_fault_sample;
          fault_hit_nxt = 1'b0;
          state_nxt     = (in_kind == stp_ramp_pkg::KIND_TICK) ? S_TICK : S_START;
        end
      end
      S_START: begin
        rpm_goal_nxt = target_in_r;
        if (ramp_in_r == 16'd0) begin
          rpm_now_nxt   = target_in_r;
          busy_flag_nxt = 1'b0;
          state_nxt     = S_FREQ;
        end else begin
          if (dreq_in_r == stp_ramp_pkg::DIR_CW) begin
            dir_logical_nxt = 1'b0;
          end else if (dreq_in_r == stp_ramp_pkg::DIR_CCW) begin
            dir_logical_nxt = 1'b1;
          end
          clock_on_nxt = 1'b1;
          div_start    = 1'b1;
          div_num      = freq_x60;
          div_den      = (steps_per_rev_r == 16'd0) ? 16'd1 : steps_per_rev_r;
          state_nxt    = S_CUR;
        end
      end
      S_CUR: begin
        if (!div_run_r) begin
          going_down_nxt = cur_down;
          if (diff16 == 16'd0) begin
            rpm_now_nxt   = target_in_r;
            busy_flag_nxt = 1'b0;
            state_nxt     = S_FREQ;
          end else begin
            rpm_now_nxt     = cur16;
            delay_count_nxt = '0;
            elapsed_nxt     = '0;
            ramp_len_nxt    = ramp_in_r;
            busy_flag_nxt   = 1'b1;
            div_start       = 1'b1;
            div_num         = {16'b0, ramp_in_r};
            div_den         = diff16;
            state_nxt       = S_DLY;
          end
        end
      end
      S_DLY: begin
        if (!div_run_r) begin
          step_delay_nxt = (div_quo_r[15:0] == 16'd0) ? 16'd1 : div_quo_r[15:0];
          rpm_now_nxt    = rpm_stepped;
          state_nxt      = S_FREQ;
        end
      end
      S_TICK: begin
        state_nxt = S_OUT;
        if (busy_flag_r) begin
          if (fault_check_en_r && (fault_in_r == fault_level_r)) begin
            clock_on_nxt  = 1'b0;
            busy_flag_nxt = 1'b0;
            fault_hit_nxt = 1'b1;
          end else begin
            elapsed_nxt     = elapsed_inc;
            delay_count_nxt = delay_inc;
            if (elapsed_inc >= ramp_len_r) begin
              rpm_now_nxt   = rpm_goal_r;
              busy_flag_nxt = 1'b0;
              state_nxt     = S_FREQ;
            end else if (delay_inc >= step_delay_r) begin
              delay_count_nxt = '0;
              rpm_now_nxt     = rpm_stepped;
              state_nxt       = S_FREQ;
            end
          end
        end
      end
      S_FREQ: begin
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        freq_now_nxt = freq_div60;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      freq_now_r    <= '0;
      rpm_now_r     <= '0;
      rpm_goal_r    <= '0;
      going_down_r  <= 1'b0;
      step_delay_r  <= '0;
      delay_count_r <= '0;
      elapsed_r     <= '0;
      ramp_len_r    <= '0;
      busy_flag_r   <= 1'b0;
      clock_on_r    <= 1'b0;
      dir_logical_r <= 1'b0;
      fault_hit_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      freq_now_r    <= freq_now_nxt;
      rpm_now_r     <= rpm_now_nxt;
      rpm_goal_r    <= rpm_goal_nxt;
      going_down_r  <= going_down_nxt;
      step_delay_r  <= step_delay_nxt;
      delay_count_r <= delay_count_nxt;
      elapsed_r     <= elapsed_nxt;
      ramp_len_r    <= ramp_len_nxt;
      busy_flag_r   <= busy_flag_nxt;
      clock_on_r    <= clock_on_nxt;
      dir_logical_r <= dir_logical_nxt;
      fault_hit_r   <= fault_hit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ramp_in_r   <= ramp_in_nxt;
    target_in_r <= target_in_nxt;
    dreq_in_r   <= dreq_in_nxt;
    fault_in_r  <= fault_in_nxt;
    if (load_out) begin
      out_freq_r  <= freq_now_r;
      out_clock_r <= clock_on_r;
      out_dir_r   <= dir_logical_r ^ swap_direction_r;
      out_duty_r  <= duty_percent_r;
      out_busy_r  <= busy_flag_r;
      out_fault_r <= fault_hit_r;
      out_rpm_r   <= rpm_now_r;
    end
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_step_freq_hz     = out_freq_r;
  assign out_clock_enable     = out_clock_r;
  assign out_dir_level        = out_dir_r;
  assign out_clk_duty_percent = out_duty_r;
  assign out_ramp_busy        = out_busy_r;
  assign out_fault_stop       = out_fault_r;
  assign out_current_rpm      = out_rpm_r;

`ifndef ASSERT_OFF
  a_busy_has_clock: assert property (@(posedge clk) disable iff (!rst_n)
    busy_flag_r |-> clock_on_r)
    else $error("ramp busy without step clock enabled");

  a_idle_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && busy_flag_r) |-> (step_delay_r != 16'd0))
    else $error("ramp running with zero step delay");

  a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result presented outside the output state");

  a_fault_stops_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |-> (!out_busy_r && !out_clock_r))
    else $error("fault result still shows a running ramp");
`endif

endmodule

[dv/stepper_linear_speed_ramp_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper linear speed ramp testbench
// Sends start and tick requests to the ramp block under random handshake
// gaps and stalls. A cycle-free model of the ramp predicts every response,
// and each response is checked field by field in arrival order. Directed
// corner cases come first, then random phases with varied register settings.
// ----------------------------------------------------------------------------
module stepper_linear_speed_ramp_tb;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 120;

  localparam logic [1:0]                         DIR_UNUSED = 2'd3;
  localparam logic [stp_ramp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [15:0] ramp_ms;
    logic [15:0] target_rpm;
    logic [1:0]  dir_request;
    logic        fault_sample;
  } ramp_req_t;

  typedef struct packed {
    logic [15:0] step_freq_hz;
    logic        clock_enable;
    logic        dir_level;
    logic [6:0]  clk_duty_percent;
    logic        ramp_busy;
    logic        fault_stop;
    logic [15:0] current_rpm;
  } drive_state_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_kind;
  logic [15:0]                         in_ramp_ms;
  logic [15:0]                         in_target_rpm;
  logic [1:0]                          in_dir_request;
  logic                                in_fault_sample;
  logic                                out_valid;
  logic                                out_stall;
  logic [15:0]                         out_step_freq_hz;
  logic                                out_clock_enable;
  logic                                out_dir_level;
  logic [6:0]                          out_clk_duty_percent;
  logic                                out_ramp_busy;
  logic                                out_fault_stop;
  logic [15:0]                         out_current_rpm;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [stp_ramp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [stp_ramp_pkg::CFG_DATA_W-1:0] cfg_data;

  // Register copies held by the model.
  logic [15:0] steps_reg;
  logic [6:0]  duty_reg;
  logic        swap_reg;
  logic        fault_en_reg;
  logic        fault_lvl_reg;

  // Ramp state held by the model.
  logic [15:0] freq_hz;
  logic [15:0] rpm_applied;
  logic [15:0] rpm_target;
  logic        ramp_down;
  logic [15:0] ms_per_step;
  logic [15:0] ms_since_step;
  logic [15:0] ms_elapsed;
  logic [15:0] ramp_length;
  logic        ramping;
  logic        step_clock_on;
  logic        dir_ccw;

  drive_state_t drive_q[$];
  int           fail_count = 0;
  int           sent_count = 0;
  int           idle_cycles = 0;
  int           tx_gap_max = 14;
  int           rx_gap_max = 14;
  int           rx_hold = 0;
  int           rx_draws = 0;
  int           rx_seen = 0;

  stepper_linear_speed_ramp uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_ramp_ms          (in_ramp_ms),
    .in_target_rpm       (in_target_rpm),
    .in_dir_request      (in_dir_request),
    .in_fault_sample     (in_fault_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_step_freq_hz    (out_step_freq_hz),
    .out_clock_enable    (out_clock_enable),
    .out_dir_level       (out_dir_level),
    .out_clk_duty_percent(out_clk_duty_percent),
    .out_ramp_busy       (out_ramp_busy),
    .out_fault_stop      (out_fault_stop),
    .out_current_rpm     (out_current_rpm),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] clamp16(input logic [31:0] value);
    return (value > 32'hFFFF) ? 16'hFFFF : value[15:0];
  endfunction

  function automatic logic [15:0] rpm_to_freq(input logic [15:0] rpm);
    return clamp16(({16'd0, rpm} * {16'd0, steps_reg}) /
                   {16'd0, stp_ramp_pkg::RPM_SECONDS});
  endfunction

  function automatic void settle_on_target();
    rpm_applied = rpm_target;
    freq_hz = rpm_to_freq(rpm_target);
    ramping = 1'b0;
  endfunction

  function automatic void step_rpm_once();
    if (rpm_applied != rpm_target) begin
      rpm_applied = ramp_down ? rpm_applied - 16'd1 : rpm_applied + 16'd1;
    end
    freq_hz = rpm_to_freq(rpm_applied);
  endfunction

  function automatic drive_state_t drive_after(input ramp_req_t req);
    drive_state_t res;
    logic [31:0]  divisor;
    logic [15:0]  rpm_from_freq;
    logic [15:0]  gap_rpm;
    logic [15:0]  per_step;
    logic         aborted;
    aborted = 1'b0;
    if (req.kind == stp_ramp_pkg::KIND_START) begin
      divisor = (steps_reg == 16'd0) ? 32'd1 : {16'd0, steps_reg};
      rpm_from_freq = clamp16(({16'd0, freq_hz} * {16'd0, stp_ramp_pkg::RPM_SECONDS}) /
                              divisor);
      rpm_target = req.target_rpm;
      if (req.ramp_ms == 16'd0) begin
        settle_on_target();
      end else begin
        if (req.dir_request == stp_ramp_pkg::DIR_CW) begin
          dir_ccw = 1'b0;
        end else if (req.dir_request == stp_ramp_pkg::DIR_CCW) begin
          dir_ccw = 1'b1;
        end
        step_clock_on = 1'b1;
        ramp_down = (req.target_rpm < rpm_from_freq);
        gap_rpm = ramp_down ? rpm_from_freq - req.target_rpm
                            : req.target_rpm - rpm_from_freq;
        if (gap_rpm == 16'd0) begin
          settle_on_target();
        end else begin
          per_step = req.ramp_ms / gap_rpm;
          ms_per_step = (per_step == 16'd0) ? 16'd1 : per_step;
          ms_since_step = 16'd0;
          ms_elapsed = 16'd0;
          ramp_length = req.ramp_ms;
          ramping = 1'b1;
          rpm_applied = rpm_from_freq;
          step_rpm_once();
        end
      end
    end else if (ramping) begin
      if (fault_en_reg && req.fault_sample == fault_lvl_reg) begin
        step_clock_on = 1'b0;
        ramping = 1'b0;
        aborted = 1'b1;
      end else begin
        ms_elapsed = ms_elapsed + 16'd1;
        ms_since_step = ms_since_step + 16'd1;
        if (ms_elapsed >= ramp_length) begin
          settle_on_target();
        end else if (ms_since_step >= ms_per_step) begin
          ms_since_step = 16'd0;
          step_rpm_once();
        end
      end
    end
    res.step_freq_hz = freq_hz;
    res.clock_enable = step_clock_on;
    res.dir_level = dir_ccw ^ swap_reg;
    res.clk_duty_percent = duty_reg;
    res.ramp_busy = ramping;
    res.fault_stop = aborted;
    res.current_rpm = rpm_applied;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_request(input ramp_req_t req);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind = req.kind;
    in_ramp_ms = req.ramp_ms;
    in_target_rpm = req.target_rpm;
    in_dir_request = req.dir_request;
    in_fault_sample = req.fault_sample;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    drive_q.push_back(drive_after(req));
    sent_count++;
  endtask

  task automatic send_start(input logic [15:0] ramp_ms, input logic [15:0] target_rpm,
                            input logic [1:0] dir_request);
    ramp_req_t req;
    req.kind = stp_ramp_pkg::KIND_START;
    req.ramp_ms = ramp_ms;
    req.target_rpm = target_rpm;
    req.dir_request = dir_request;
    req.fault_sample = 1'($urandom_range(0, 1));
    send_request(req);
  endtask

  task automatic send_tick(input logic fault_sample);
    ramp_req_t req;
    req.kind = stp_ramp_pkg::KIND_TICK;
    req.ramp_ms = 16'($urandom_range(0, 16'hFFFF));
    req.target_rpm = 16'($urandom_range(0, 16'hFFFF));
    req.dir_request = 2'($urandom_range(0, 3));
    req.fault_sample = fault_sample;
    send_request(req);
  endtask

  // The sender holds off until every outstanding request has been answered.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [stp_ramp_pkg::CFG_IDX_W-1:0] index,
                           input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (index)
      stp_ramp_pkg::REG_STEPS_PER_REV:  steps_reg = data;
      stp_ramp_pkg::REG_DUTY_PERCENT:   duty_reg = data[6:0];
      stp_ramp_pkg::REG_SWAP_DIRECTION: swap_reg = data[0];
      stp_ramp_pkg::REG_FAULT_CHECK_EN: fault_en_reg = data[0];
      stp_ramp_pkg::REG_FAULT_LEVEL:    fault_lvl_reg = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_idle_tick();
    send_tick(1'b1);
  endtask

  task automatic test_zero_ramp();
    send_start(16'd0, 16'hFFFF, stp_ramp_pkg::DIR_CCW);
    send_start(16'd0, 16'd0, stp_ramp_pkg::DIR_CW);
    send_start(16'd0, 16'd120, stp_ramp_pkg::DIR_CCW);
  endtask

  task automatic test_zero_difference();
    send_start(16'hFFFF, 16'd120, stp_ramp_pkg::DIR_CCW);
  endtask

  task automatic test_slow_ramp_down();
    send_start(16'hFFFF, 16'd0, DIR_UNUSED);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_restart_no_overshoot();
    send_start(16'd7, rpm_applied + 16'd4, stp_ramp_pkg::DIR_CW);
    repeat (7) send_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic test_short_delay();
    send_start(16'd1, 16'hFFFF, stp_ramp_pkg::DIR_KEEP);
    send_tick(1'b0);
  endtask

  task automatic test_fault_stop();
    drain_results();
    write_reg(stp_ramp_pkg::REG_FAULT_CHECK_EN, 16'd1);
    write_reg(stp_ramp_pkg::REG_FAULT_LEVEL, 16'd1);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_start(16'd20, 16'd10, stp_ramp_pkg::DIR_CCW);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  task automatic pick_settings();
    logic [15:0] steps;
    logic [15:0] duty;
    case ($urandom_range(0, 5))
      0: steps = 16'd0;
      1: steps = 16'd1;
      2: steps = 16'hFFFF;
      3: steps = stp_ramp_pkg::STEPS_RESET;
      4: steps = 16'($urandom_range(1, 400));
      default: steps = 16'($urandom_range(0, 16'hFFFF));
    endcase
    case ($urandom_range(0, 3))
      0: duty = 16'd0;
      1: duty = 16'd100;
      2: duty = 16'd127;
      default: duty = 16'($urandom_range(0, 127));
    endcase
    write_reg(stp_ramp_pkg::REG_STEPS_PER_REV, steps);
    write_reg(stp_ramp_pkg::REG_DUTY_PERCENT, duty);
    write_reg(stp_ramp_pkg::REG_SWAP_DIRECTION, 16'($urandom_range(0, 1)));
    write_reg(stp_ramp_pkg::REG_FAULT_CHECK_EN, 16'($urandom_range(0, 1)));
    write_reg(stp_ramp_pkg::REG_FAULT_LEVEL, 16'($urandom_range(0, 1)));
    tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
  endtask

  task automatic run_ramp_sequence();
    logic [15:0] ramp_ms;
    logic [15:0] target_rpm;
    logic [15:0] delta;
    int          ticks;
    logic        fault;
    case ($urandom_range(0, 19))
      0: ramp_ms = 16'd0;
      1, 2: ramp_ms = 16'($urandom_range(0, 16'hFFFF));
      3, 4, 5: ramp_ms = 16'($urandom_range(41, 400));
      default: ramp_ms = 16'($urandom_range(1, 40));
    endcase
    delta = 16'($urandom_range(0, 24));
    case ($urandom_range(0, 9))
      0: target_rpm = 16'($urandom_range(0, 16'hFFFF));
      1: target_rpm = rpm_applied;
      2, 3, 4, 5: target_rpm = (rpm_applied > 16'hFFFF - delta) ? 16'hFFFF
                                                                 : rpm_applied + delta;
      default: target_rpm = (rpm_applied < delta) ? 16'd0 : rpm_applied - delta;
    endcase
    send_start(ramp_ms, target_rpm, 2'($urandom_range(0, 3)));
    ticks = (ramp_ms > 16'd60) ? $urandom_range(0, 60) : ramp_ms + $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) begin
      ticks = $urandom_range(0, ticks);
    end
    repeat (ticks) begin
      if (fault_en_reg && $urandom_range(0, 29) != 0) begin
        fault = ~fault_lvl_reg;
      end else begin
        fault = 1'($urandom_range(0, 1));
      end
      send_tick(fault);
    end
  endtask

  task automatic test_random_traffic();
    int target_count;
    target_count = sent_count + RANDOM_ITEMS;
    while (sent_count < target_count) begin
      drain_results();
      pick_settings();
      repeat ($urandom_range(4, 10)) begin
        run_ramp_sequence();
        if ($urandom_range(0, 3) == 0) begin
          drain_results();
        end
      end
    end
    tx_gap_max = 14;
    rx_gap_max = 14;
  endtask

  // Response checker.
  always @(posedge clk) begin : check_responses
    drive_state_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (drive_q.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        want = drive_q.pop_front();
        check_field("step_freq_hz", want.step_freq_hz, out_step_freq_hz);
        check_field("clock_enable", 16'(want.clock_enable), 16'(out_clock_enable));
        check_field("dir_level", 16'(want.dir_level), 16'(out_dir_level));
        check_field("clk_duty_percent", 16'(want.clk_duty_percent),
                    16'(out_clk_duty_percent));
        check_field("ramp_busy", 16'(want.ramp_busy), 16'(out_ramp_busy));
        check_field("fault_stop", 16'(want.fault_stop), 16'(out_fault_stop));
        check_field("current_rpm", want.current_rpm, out_current_rpm);
      end
      rx_draws++;
    end
  end

  // Output stall generator: a new hold is drawn after every taken response.
  always @(negedge clk) begin
    if (rx_seen != rx_draws) begin
      rx_seen = rx_draws;
      rx_hold = $urandom_range(0, rx_gap_max);
    end
    if (rx_hold > 0) begin
      out_stall = 1'b1;
      rx_hold--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = stp_ramp_pkg::KIND_TICK;
    in_ramp_ms = 16'd0;
    in_target_rpm = 16'd0;
    in_dir_request = stp_ramp_pkg::DIR_KEEP;
    in_fault_sample = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = stp_ramp_pkg::REG_STEPS_PER_REV;
    cfg_data = 16'd0;
    steps_reg = stp_ramp_pkg::STEPS_RESET;
    duty_reg = stp_ramp_pkg::DUTY_RESET;
    swap_reg = 1'b0;
    fault_en_reg = 1'b0;
    fault_lvl_reg = 1'b0;
    freq_hz = 16'd0;
    rpm_applied = 16'd0;
    rpm_target = 16'd0;
    ramp_down = 1'b0;
    ms_per_step = 16'd0;
    ms_since_step = 16'd0;
    ms_elapsed = 16'd0;
    ramp_length = 16'd0;
    ramping = 1'b0;
    step_clock_on = 1'b0;
    dir_ccw = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_idle_tick();
    test_zero_ramp();
    test_zero_difference();
    test_slow_ramp_down();
    test_restart_no_overshoot();
    test_short_delay();
    test_fault_stop();
    test_random_traffic();

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[stepper_linear_speed_ramp.f]
rtl/stp_ramp_pkg.sv
rtl/stepper_linear_speed_ramp.sv
dv/stepper_linear_speed_ramp_tb.sv
